// ===== sv/jls_pkg.sv =====
package jls_pkg;

	// Input commands
	localparam logic [1:0] CMD_MATRIX = 2'd0;
	localparam logic [1:0] CMD_RHS    = 2'd1;
	localparam logic [1:0] CMD_SOLVE  = 2'd2;

	// Configuration register indexes
	localparam logic [1:0] REG_SIZE     = 2'd0;
	localparam logic [1:0] REG_ACCURACY = 2'd1;
	localparam logic [1:0] REG_LIMIT    = 2'd2;

	// Reset values of the configuration registers
	localparam logic [5:0]  SIZE_RESET     = 6'd32;
	localparam logic [31:0] ACCURACY_RESET = 32'h3A83126F;
	localparam logic [15:0] LIMIT_RESET    = 16'd1000;

	// Floating point unit operations
	localparam logic [1:0] FOP_ADD = 2'd0;
	localparam logic [1:0] FOP_SUB = 2'd1;
	localparam logic [1:0] FOP_MUL = 2'd2;
	localparam logic [1:0] FOP_DIV = 2'd3;

	// Single precision constants
	localparam logic [31:0] FP_QNAN_DEFAULT = 32'hFFC00000;
	localparam logic [31:0] FP_QNAN_POS     = 32'h7FC00000;
	localparam logic [31:0] FP_QUIET_BIT    = 32'h00400000;
	localparam logic [31:0] FP_ZERO         = 32'h00000000;
	localparam logic [7:0]  FP_EXP_MAX      = 8'hFF;
	localparam logic signed [10:0] FP_BIAS  = 11'sd127;

	typedef struct packed {
		logic [1:0]  op;
		logic [31:0] a;
		logic [31:0] b;
	} fpu_req_t;

	typedef struct packed {
		logic               sign;
		logic signed [10:0] exp;
		logic [23:0]        mant;
		logic               nan;
		logic               inf;
		logic               zero;
	} fp_unp_t;

	// Split a single into sign, biased exponent field (1 for subnormals) and 24-bit significand
	function automatic fp_unp_t fp_unpack(input logic [31:0] x);
		fp_unp_t u;
		u.sign = x[31];
		u.exp  = (x[30:23] == 8'd0) ? 11'sd1 : $signed({3'b000, x[30:23]});
		u.mant = {x[30:23] != 8'd0, x[22:0]};
		u.nan  = (x[30:23] == FP_EXP_MAX) && (x[22:0] != 23'd0);
		u.inf  = (x[30:23] == FP_EXP_MAX) && (x[22:0] == 23'd0);
		u.zero = (x[30:0] == 31'd0);
		return u;
	endfunction

	// Ordered less-than, false on NaN and on two zeros
	function automatic logic fp_less(input logic [31:0] a, input logic [31:0] b);
		logic a_nan;
		logic b_nan;
		logic r;
		a_nan = (a[30:23] == FP_EXP_MAX) && (a[22:0] != 23'd0);
		b_nan = (b[30:23] == FP_EXP_MAX) && (b[22:0] != 23'd0);
		if (a_nan || b_nan) begin
			r = 1'b0;
		end else if ((a[30:0] == 31'd0) && (b[30:0] == 31'd0)) begin
			r = 1'b0;
		end else if (a[31] != b[31]) begin
			r = a[31];
		end else if (!a[31]) begin
			r = a[30:0] < b[30:0];
		end else begin
			r = a[30:0] > b[30:0];
		end
		return r;
	endfunction

endpackage

// ===== sv/jls_ifs.sv =====
interface jls_req_if;
	logic        valid;
	logic        ready;
	logic [1:0]  command;
	logic [4:0]  row;
	logic [4:0]  col;
	logic [31:0] value;

	modport source (output valid, output command, output row, output col, output value,
		input ready);
	modport sink (input valid, input command, input row, input col, input value,
		output ready);
endinterface

interface jls_rsp_if;
	logic        valid;
	logic        ready;
	logic [4:0]  index;
	logic [31:0] solution;
	logic        converged;
	logic [15:0] sweeps_used;
	logic        last;

	modport source (output valid, output index, output solution, output converged,
		output sweeps_used, output last, input ready);
	modport sink (input valid, input index, input solution, input converged,
		input sweeps_used, input last, output ready);
endinterface

interface jls_cfg_if;
	logic        valid;
	logic        ready;
	logic [1:0]  index;
	logic [31:0] data;

	modport source (output valid, output index, output data, input ready);
	modport sink (input valid, input index, input data, output ready);
endinterface

// ===== sv/jls_fpu.sv =====
module jls_fpu
	import jls_pkg::*;
(
	input  logic        clk,
	input  logic        arst_n,
	input  logic        start,
	input  fpu_req_t    req,
	output logic        done,
	output logic [31:0] result
);

	localparam logic [2:0] F_IDLE = 3'd0;
	localparam logic [2:0] F_PREN = 3'd1;
	localparam logic [2:0] F_DIV  = 3'd2;
	localparam logic [2:0] F_NORM = 3'd3;
	localparam logic [2:0] F_RND  = 3'd4;

	logic [2:0]         state_q;
	logic               done_q;
	logic [31:0]        result_q;
	logic [49:0]        m_q;
	logic signed [10:0] e_q;
	logic               sign_q;
	logic [23:0]        da_q;
	logic [23:0]        db_q;
	logic [25:0]        rem_q;
	logic [5:0]         cnt_q;

	fp_unp_t            ua;
	fp_unp_t            ub;
	logic               sb_eff;
	logic               sx;
	logic               spec_hit;
	logic [31:0]        spec_val;

	// Alignment path of the adder
	logic               a_big;
	logic signed [10:0] big_e;
	logic [23:0]        big_m;
	logic               big_s;
	logic signed [10:0] sml_e;
	logic [23:0]        sml_m;
	logic               sml_s;
	logic [10:0]        dexp;
	logic [49:0]        big_ext;
	logic [49:0]        sml_ext;
	logic [49:0]        sml_sh;
	logic               sml_st;
	logic [49:0]        m_add;
	logic               s_add;
	logic [47:0]        prod;

	// Division step
	logic               div_ge;
	logic [25:0]        div_rem;

	// Normalise and round
	logic               norm_fin;
	logic               rnd_up;
	logic [24:0]        rnd_sum;
	logic signed [10:0] rnd_e;
	logic [22:0]        rnd_f;
	logic [31:0]        rnd_val;

	// Decode operands and catch special values at start
	always_comb begin
		ua       = fp_unpack(req.a);
		ub       = fp_unpack(req.b);
		sb_eff   = ub.sign ^ (req.op == FOP_SUB);
		sx       = ua.sign ^ ub.sign;
		spec_hit = 1'b1;
		spec_val = FP_QNAN_DEFAULT;
		if (ua.nan) begin
			spec_val = req.a | FP_QUIET_BIT;
		end else if (ub.nan) begin
			spec_val = req.b | FP_QUIET_BIT;
		end else begin
			case (req.op) inside
				FOP_ADD, FOP_SUB: begin
					if (ua.inf && ub.inf) begin
						spec_val = (ua.sign != sb_eff) ? FP_QNAN_DEFAULT
							: {ua.sign, FP_EXP_MAX, 23'd0};
					end else if (ua.inf) begin
						spec_val = {ua.sign, FP_EXP_MAX, 23'd0};
					end else if (ub.inf) begin
						spec_val = {sb_eff, FP_EXP_MAX, 23'd0};
					end else begin
						spec_hit = 1'b0;
					end
				end
				FOP_MUL: begin
					if ((ua.inf && ub.zero) || (ua.zero && ub.inf)) begin
						spec_val = FP_QNAN_DEFAULT;
					end else if (ua.inf || ub.inf) begin
						spec_val = {sx, FP_EXP_MAX, 23'd0};
					end else begin
						spec_hit = 1'b0;
					end
				end
				default: begin
					if ((ua.zero && ub.zero) || (ua.inf && ub.inf)) begin
						spec_val = FP_QNAN_DEFAULT;
					end else if (ua.inf || ub.zero) begin
						spec_val = {sx, FP_EXP_MAX, 23'd0};
					end else if (ub.inf || ua.zero) begin
						spec_val = {sx, 31'd0};
					end else begin
						spec_hit = 1'b0;
					end
				end
			endcase
		end
	end

	// Align the smaller addend and add or subtract, and form the significand product
	always_comb begin
		a_big   = {ua.exp, ua.mant} >= {ub.exp, ub.mant};
		big_e   = a_big ? ua.exp : ub.exp;
		big_m   = a_big ? ua.mant : ub.mant;
		big_s   = a_big ? ua.sign : sb_eff;
		sml_e   = a_big ? ub.exp : ua.exp;
		sml_m   = a_big ? ub.mant : ua.mant;
		sml_s   = a_big ? sb_eff : ua.sign;
		dexp    = 11'(big_e - sml_e);
		big_ext = {1'b0, big_m, 25'd0};
		sml_ext = {1'b0, sml_m, 25'd0};
		if (dexp >= 11'd50) begin
			sml_sh = 50'd0;
			sml_st = sml_m != 24'd0;
		end else begin
			sml_sh = sml_ext >> dexp[5:0];
			sml_st = |(sml_ext & ~({50{1'b1}} << dexp[5:0]));
		end
		sml_sh[0] = sml_sh[0] | sml_st;
		m_add     = (big_s ^ sml_s) ? (big_ext - sml_sh) : (big_ext + sml_sh);
		s_add     = (m_add == 50'd0) ? (ua.sign & sb_eff) : big_s;
		prod      = ua.mant * ub.mant;
	end

	// One restoring division step
	always_comb begin
		div_ge  = rem_q >= {2'b00, db_q};
		div_rem = div_ge ? (rem_q - {2'b00, db_q}) : rem_q;
	end

	// Round to nearest even and pack
	always_comb begin
		norm_fin = !m_q[49] && !(!m_q[48] && (e_q > 11'sd1)) && !(e_q < 11'sd1);
		rnd_up   = m_q[24] & ((|m_q[23:0]) | m_q[25]);
		rnd_sum  = {1'b0, m_q[48:25]} + {24'd0, rnd_up};
		if (rnd_sum[24]) begin
			rnd_e = e_q + 11'sd1;
			rnd_f = 23'd0;
		end else if (rnd_sum[23]) begin
			rnd_e = e_q;
			rnd_f = rnd_sum[22:0];
		end else begin
			rnd_e = 11'sd0;
			rnd_f = rnd_sum[22:0];
		end
		if (rnd_e >= 11'sd255) begin
			rnd_val = {sign_q, FP_EXP_MAX, 23'd0};
		end else begin
			rnd_val = {sign_q, rnd_e[7:0], rnd_f};
		end
	end

	// Sequence the unit
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= F_IDLE;
			done_q  <= 1'b0;
		end else begin
			done_q <= 1'b0;
			unique case (state_q)
				F_IDLE: begin
					if (start) begin
						if (spec_hit) begin
							done_q <= 1'b1;
						end else if (req.op == FOP_DIV) begin
							state_q <= F_PREN;
						end else begin
							state_q <= F_NORM;
						end
					end
				end
				F_PREN: begin
					if (da_q[23] && db_q[23]) begin
						state_q <= F_DIV;
					end
				end
				F_DIV: begin
					if (cnt_q == 6'd48) begin
						state_q <= F_NORM;
					end
				end
				F_NORM: begin
					if (m_q == 50'd0) begin
						done_q  <= 1'b1;
						state_q <= F_IDLE;
					end else if (norm_fin) begin
						state_q <= F_RND;
					end
				end
				F_RND: begin
					done_q  <= 1'b1;
					state_q <= F_IDLE;
				end
				default: state_q <= F_IDLE;
			endcase
		end
	end

	// Datapath registers
	always_ff @(posedge clk) begin
		case (state_q)
			F_IDLE: begin
				if (start) begin
					result_q <= spec_val;
					cnt_q    <= 6'd0;
					da_q     <= ua.mant;
					db_q     <= ub.mant;
					case (req.op) inside
						FOP_ADD, FOP_SUB: begin
							m_q    <= m_add;
							e_q    <= big_e;
							sign_q <= s_add;
						end
						FOP_MUL: begin
							m_q    <= {prod, 2'b00};
							e_q    <= ua.exp + ub.exp - FP_BIAS;
							sign_q <= sx;
						end
						default: begin
							m_q    <= 50'd0;
							e_q    <= ua.exp - ub.exp + FP_BIAS;
							sign_q <= sx;
						end
					endcase
				end
			end
			F_PREN: begin
				if (da_q[23] && db_q[23]) begin
					rem_q <= {2'b00, da_q};
					cnt_q <= 6'd0;
					m_q   <= 50'd0;
				end else begin
					// Shift subnormal significands up, adjusting the quotient exponent to match
					if (!da_q[23]) begin
						da_q <= {da_q[22:0], 1'b0};
					end
					if (!db_q[23]) begin
						db_q <= {db_q[22:0], 1'b0};
					end
					e_q <= e_q - {10'd0, !da_q[23]} + {10'd0, !db_q[23]};
				end
			end
			F_DIV: begin
				cnt_q <= cnt_q + 6'd1;
				rem_q <= {div_rem[24:0], 1'b0};
				if (cnt_q == 6'd48) begin
					m_q <= {m_q[48:0], div_ge | (div_rem != 26'd0)};
				end else begin
					m_q <= {m_q[48:0], div_ge};
				end
			end
			F_NORM: begin
				if (m_q == 50'd0) begin
					result_q <= {sign_q, 31'd0};
				end else if (m_q[49]) begin
					m_q <= {1'b0, m_q[49:2], m_q[1] | m_q[0]};
					e_q <= e_q + 11'sd1;
				end else if (!m_q[48] && (e_q > 11'sd1)) begin
					m_q <= {m_q[48:0], 1'b0};
					e_q <= e_q - 11'sd1;
				end else if (e_q < 11'sd1) begin
					// Denormalise, dropping bits into the sticky position
					if (m_q[49:1] == 49'd0) begin
						e_q <= 11'sd1;
					end else begin
						m_q <= {1'b0, m_q[49:2], m_q[1] | m_q[0]};
						e_q <= e_q + 11'sd1;
					end
				end
			end
			F_RND: begin
				result_q <= rnd_val;
			end
			default: ;
		endcase
	end

	assign done   = done_q;
	assign result = result_q;

endmodule

// ===== sv/jacobi_linear_solver.sv =====
// Jacobi solver around one shared multi-cycle single precision unit.
// Load requests (matrix or right-hand element) are taken one per cycle, back to back,
// but only while no solve is running. A solve runs its sweeps through the shared
// unit one add, multiply or divide at a time, then sends the result elements in
// order, each held until the result port is ready.
// Reset clears control, configuration and the vector valid bits at once;
// the matrix and right-hand stores hold no reset value.
module jacobi_linear_solver
	import jls_pkg::*;
#(
	parameter int MAX_N = 32
) (
	input  logic clk,
	input  logic arst_n,
	jls_req_if.sink   req_ch,
	jls_rsp_if.source rsp_ch,
	jls_cfg_if.sink   cfg
);

	localparam int IW = $clog2(MAX_N);
	localparam int AW = $clog2(MAX_N * MAX_N);

	localparam logic [4:0] S_IDLE      = 5'd0;
	localparam logic [4:0] S_RD        = 5'd1;
	localparam logic [4:0] S_MUL       = 5'd2;
	localparam logic [4:0] S_MUL_W     = 5'd3;
	localparam logic [4:0] S_ADD       = 5'd4;
	localparam logic [4:0] S_ADD_W     = 5'd5;
	localparam logic [4:0] S_NUM       = 5'd6;
	localparam logic [4:0] S_SUB       = 5'd7;
	localparam logic [4:0] S_SUB_W     = 5'd8;
	localparam logic [4:0] S_DIV       = 5'd9;
	localparam logic [4:0] S_DIV_W     = 5'd10;
	localparam logic [4:0] S_CHG_RD    = 5'd11;
	localparam logic [4:0] S_CHG_SUB   = 5'd12;
	localparam logic [4:0] S_CHG_SUB_W = 5'd13;
	localparam logic [4:0] S_CHG_ADD   = 5'd14;
	localparam logic [4:0] S_CHG_ADD_W = 5'd15;
	localparam logic [4:0] S_CHECK     = 5'd16;
	localparam logic [4:0] S_OUT_RD    = 5'd17;
	localparam logic [4:0] S_OUT       = 5'd18;

	logic [4:0]    state_q;
	logic [5:0]    size_q;
	logic [31:0]   acc_q;
	logic [15:0]   limit_q;
	logic [IW-1:0] i_q;
	logic [IW-1:0] j_q;
	logic [IW-1:0] last_q;
	logic [15:0]   sweeps_q;
	logic          conv_q;
	logic          bsel_q;
	logic [31:0]   sum_q;
	logic [31:0]   change_q;
	logic [31:0]   tmp_q;
	logic [31:0]   diag_q;

	// Stores
	logic [31:0]    mat_mem [MAX_N*MAX_N];
	logic [31:0]    rhs_mem [MAX_N];
	logic [31:0]    va_mem  [MAX_N];
	logic [31:0]    vb_mem  [MAX_N];
	logic [MAX_N-1:0] vld_a_q;
	logic [MAX_N-1:0] vld_b_q;
	logic [31:0]    mat_rd_q;
	logic [31:0]    rhs_rd_q;
	logic [31:0]    va_rd_q;
	logic [31:0]    vb_rd_q;
	logic           va_ok_q;
	logic           vb_ok_q;

	logic          accept;
	logic          mat_we;
	logic          rhs_we;
	logic [AW-1:0] mat_waddr;
	logic [AW-1:0] mat_raddr;
	logic [IW-1:0] v_raddr;
	logic [31:0]   va;
	logic [31:0]   vb;
	logic [31:0]   cur;
	logic [31:0]   nxt;
	logic          vec_we;
	logic [31:0]   vec_wdata;
	logic [31:0]   safe_val;
	logic          diag_zero;
	logic [15:0]   sw_next;
	logic [IW:0]   n_clamp;

	logic          fpu_start;
	fpu_req_t      fpu_req;
	logic          fpu_done;
	logic [31:0]   fpu_result;

	jls_fpu u_fpu (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (fpu_start),
		.req    (fpu_req),
		.done   (fpu_done),
		.result (fpu_result)
	);

	// Decode the request and addresses
	always_comb begin
		accept    = req_ch.valid && req_ch.ready;
		mat_we    = accept && (req_ch.command == CMD_MATRIX) && (int'(req_ch.row) < MAX_N)
			&& (int'(req_ch.col) < MAX_N);
		rhs_we    = accept && (req_ch.command == CMD_RHS) && (int'(req_ch.row) < MAX_N);
		mat_waddr = AW'(int'(req_ch.row) * MAX_N + int'(req_ch.col));
		mat_raddr = AW'(int'(i_q) * MAX_N + int'((state_q == S_NUM) ? i_q : j_q));
		v_raddr   = (state_q == S_RD) ? j_q : i_q;
		va        = va_ok_q ? va_rd_q : FP_ZERO;
		vb        = vb_ok_q ? vb_rd_q : FP_ZERO;
		cur       = bsel_q ? vb : va;
		nxt       = bsel_q ? va : vb;
		sw_next   = sweeps_q + 16'd1;
		if (size_q == 6'd0) begin
			n_clamp = (IW+1)'(1);
		end else if (int'(size_q) > MAX_N) begin
			n_clamp = (IW+1)'(MAX_N);
		end else begin
			n_clamp = (IW+1)'(size_q);
		end
	end

	// Zero diagonal: signed infinity, or NaN for a zero or NaN numerator
	always_comb begin
		diag_zero = diag_q[30:0] == 31'd0;
		if ((tmp_q[30:0] == 31'd0) || (tmp_q[30:0] > {FP_EXP_MAX, 23'd0})) begin
			safe_val = FP_QNAN_POS;
		end else begin
			safe_val = {tmp_q[31] ^ diag_q[31], FP_EXP_MAX, 23'd0};
		end
		vec_we    = ((state_q == S_DIV) && diag_zero) || ((state_q == S_DIV_W) && fpu_done);
		vec_wdata = (state_q == S_DIV) ? safe_val : fpu_result;
	end

	// Issue requests to the shared unit
	always_comb begin
		fpu_start = 1'b0;
		fpu_req   = '{op: FOP_ADD, a: sum_q, b: tmp_q};
		unique case (state_q)
			S_MUL: begin
				fpu_start = 1'b1;
				fpu_req   = '{op: FOP_MUL, a: mat_rd_q, b: cur};
			end
			S_ADD: begin
				fpu_start = 1'b1;
				fpu_req   = '{op: FOP_ADD, a: sum_q, b: tmp_q};
			end
			S_SUB: begin
				fpu_start = 1'b1;
				fpu_req   = '{op: FOP_SUB, a: rhs_rd_q, b: sum_q};
			end
			S_DIV: begin
				fpu_start = !diag_zero;
				fpu_req   = '{op: FOP_DIV, a: tmp_q, b: diag_q};
			end
			S_CHG_SUB: begin
				fpu_start = 1'b1;
				fpu_req   = '{op: FOP_SUB, a: nxt, b: cur};
			end
			S_CHG_ADD: begin
				fpu_start = 1'b1;
				fpu_req   = '{op: FOP_ADD, a: change_q, b: {1'b0, tmp_q[30:0]}};
			end
			default: ;
		endcase
	end

	// Matrix and right-hand stores
	always_ff @(posedge clk) begin
		if (mat_we) begin
			mat_mem[mat_waddr] <= req_ch.value;
		end
		mat_rd_q <= mat_mem[mat_raddr];
	end

	always_ff @(posedge clk) begin
		if (rhs_we) begin
			rhs_mem[IW'(req_ch.row)] <= req_ch.value;
		end
		rhs_rd_q <= rhs_mem[i_q];
	end

	// Ping-pong vector banks, written into the bank that is not current
	always_ff @(posedge clk) begin
		if (vec_we && bsel_q) begin
			va_mem[i_q] <= vec_wdata;
		end
		if (vec_we && !bsel_q) begin
			vb_mem[i_q] <= vec_wdata;
		end
		va_rd_q <= va_mem[v_raddr];
		vb_rd_q <= vb_mem[v_raddr];
		va_ok_q <= vld_a_q[v_raddr];
		vb_ok_q <= vld_b_q[v_raddr];
	end

	// Configuration writes
	assign cfg.ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			size_q  <= SIZE_RESET;
			acc_q   <= ACCURACY_RESET;
			limit_q <= LIMIT_RESET;
		end else if (cfg.valid) begin
			unique case (cfg.index)
				REG_SIZE:     size_q  <= cfg.data[5:0];
				REG_ACCURACY: acc_q   <= cfg.data;
				REG_LIMIT:    limit_q <= cfg.data[15:0];
				default: ;
			endcase
		end
	end

	// Sweep sequencer
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q  <= S_IDLE;
			i_q      <= '0;
			j_q      <= '0;
			last_q   <= '0;
			sweeps_q <= 16'd0;
			conv_q   <= 1'b0;
			bsel_q   <= 1'b0;
			vld_a_q  <= '0;
			vld_b_q  <= '0;
			sum_q    <= FP_ZERO;
			change_q <= FP_ZERO;
			tmp_q    <= FP_ZERO;
			diag_q   <= FP_ZERO;
		end else begin
			if (vec_we && bsel_q) begin
				vld_a_q[i_q] <= 1'b1;
			end
			if (vec_we && !bsel_q) begin
				vld_b_q[i_q] <= 1'b1;
			end
			unique case (state_q)
				S_IDLE: begin
					if (accept && (req_ch.command == CMD_SOLVE)) begin
						vld_a_q  <= '0;
						vld_b_q  <= '0;
						last_q   <= IW'(n_clamp - (IW+1)'(1));
						sweeps_q <= 16'd0;
						conv_q   <= 1'b0;
						i_q      <= '0;
						j_q      <= '0;
						sum_q    <= FP_ZERO;
						change_q <= FP_ZERO;
						state_q  <= (limit_q == 16'd0) ? S_OUT_RD : S_RD;
					end
				end
				S_RD: begin
					// Skip the diagonal term
					if (j_q == i_q) begin
						if (j_q == last_q) begin
							state_q <= S_NUM;
						end else begin
							j_q <= j_q + IW'(1);
						end
					end else begin
						state_q <= S_MUL;
					end
				end
				S_MUL: state_q <= S_MUL_W;
				S_MUL_W: begin
					if (fpu_done) begin
						tmp_q   <= fpu_result;
						state_q <= S_ADD;
					end
				end
				S_ADD: state_q <= S_ADD_W;
				S_ADD_W: begin
					if (fpu_done) begin
						sum_q <= fpu_result;
						if (j_q == last_q) begin
							state_q <= S_NUM;
						end else begin
							j_q     <= j_q + IW'(1);
							state_q <= S_RD;
						end
					end
				end
				S_NUM: state_q <= S_SUB;
				S_SUB: begin
					diag_q  <= mat_rd_q;
					state_q <= S_SUB_W;
				end
				S_SUB_W: begin
					if (fpu_done) begin
						tmp_q   <= fpu_result;
						state_q <= S_DIV;
					end
				end
				S_DIV, S_DIV_W: begin
					if (state_q == S_DIV && !diag_zero) begin
						state_q <= S_DIV_W;
					end else if (vec_we) begin
						// Row written: next row, or measure the change
						if (i_q == last_q) begin
							i_q     <= '0;
							state_q <= S_CHG_RD;
						end else begin
							i_q     <= i_q + IW'(1);
							j_q     <= '0;
							sum_q   <= FP_ZERO;
							state_q <= S_RD;
						end
					end
				end
				S_CHG_RD: state_q <= S_CHG_SUB;
				S_CHG_SUB: state_q <= S_CHG_SUB_W;
				S_CHG_SUB_W: begin
					if (fpu_done) begin
						tmp_q   <= fpu_result;
						state_q <= S_CHG_ADD;
					end
				end
				S_CHG_ADD: state_q <= S_CHG_ADD_W;
				S_CHG_ADD_W: begin
					if (fpu_done) begin
						change_q <= fpu_result;
						if (i_q == last_q) begin
							state_q <= S_CHECK;
						end else begin
							i_q     <= i_q + IW'(1);
							state_q <= S_CHG_RD;
						end
					end
				end
				S_CHECK: begin
					bsel_q   <= !bsel_q;
					sweeps_q <= sw_next;
					i_q      <= '0;
					j_q      <= '0;
					sum_q    <= FP_ZERO;
					change_q <= FP_ZERO;
					if (fp_less(change_q, acc_q)) begin
						conv_q  <= 1'b1;
						state_q <= S_OUT_RD;
					end else if (sw_next >= limit_q) begin
						state_q <= S_OUT_RD;
					end else begin
						state_q <= S_RD;
					end
				end
				S_OUT_RD: state_q <= S_OUT;
				S_OUT: begin
					if (rsp_ch.ready) begin
						if (i_q == last_q) begin
							state_q <= S_IDLE;
						end else begin
							i_q     <= i_q + IW'(1);
							state_q <= S_OUT_RD;
						end
					end
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	// Result port
	assign req_ch.ready       = state_q == S_IDLE;
	assign rsp_ch.valid       = state_q == S_OUT;
	assign rsp_ch.index       = 5'(i_q);
	assign rsp_ch.solution    = cur;
	assign rsp_ch.converged   = conv_q;
	assign rsp_ch.sweeps_used = sweeps_q;
	assign rsp_ch.last        = i_q == last_q;

`ifndef SYNTHESIS
	a_no_overlap: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_ch.valid |-> !req_ch.ready)
		else $error("result shown while new requests are taken");

	a_fpu_quiet_idle: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == S_IDLE |-> !fpu_done)
		else $error("arithmetic unit finished with no solve running");

	a_sweep_bound: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_ch.valid |-> sweeps_q <= limit_q)
		else $error("sweep count beyond the limit");

	a_last_ends: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_ch.valid && rsp_ch.ready && rsp_ch.last |=> state_q == S_IDLE)
		else $error("solver did not return to idle after the last element");

	a_conv_swept: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_ch.valid && rsp_ch.converged |-> sweeps_q != 16'd0)
		else $error("convergence flagged without a sweep");
`endif

endmodule

// ===== tb/sv/jacobi_linear_solver_chk.sv =====
`timescale 1ns / 100ps

module jacobi_linear_solver_chk
	import jls_pkg::*;
#(
	parameter int MAX_N = 32
) (
	input  logic clk,
	input  logic arst_n,
	jls_req_if   req,
	jls_rsp_if   rsp,
	jls_cfg_if   cfg,
	output int   fails,
	output int   outstanding
);

	typedef struct {
		logic [4:0]  index;
		logic [31:0] solution;
		logic        converged;
		logic [15:0] sweeps_used;
		logic        last;
	} solution_t;

	localparam logic [31:0] QNAN = 32'h7FC00000;

	solution_t   solution_q[$];
	logic [31:0] mat_mem[MAX_N*MAX_N];
	logic [31:0] rhs_mem[MAX_N];
	logic [5:0]  size_reg;
	logic [31:0] acc_reg;
	logic [15:0] limit_reg;

	function automatic logic is_nan(input logic [31:0] x);
		return (x[30:23] == 8'hFF) && (x[22:0] != 23'd0);
	endfunction

	function automatic logic is_inf(input logic [31:0] x);
		return (x[30:23] == 8'hFF) && (x[22:0] == 23'd0);
	endfunction

	function automatic logic is_zero(input logic [31:0] x);
		return x[30:0] == 31'd0;
	endfunction

	// Split into exponent field (1 for subnormals) and significand with hidden bit
	function automatic void split(input logic [31:0] x, output int e, output logic [127:0] m);
		e = (x[30:23] == 8'd0) ? 1 : int'(x[30:23]);
		m = 128'({x[30:23] != 8'd0, x[22:0]});
	endfunction

	// Round to nearest even and pack; value is m * 2^(e-153)
	function automatic logic [31:0] round_pack(input logic s, input int e, input logic [127:0] m);
		logic [127:0] keep;
		if (m == 0)
			return {s, 31'd0};
		while (m >= (128'd1 << 27)) begin
			m = (m >> 1) | (m & 128'd1);
			e++;
		end
		while (m < (128'd1 << 26) && e > 1) begin
			m = m << 1;
			e--;
		end
		while (e < 1) begin
			m = (m >> 1) | (m & 128'd1);
			e++;
		end
		keep = m >> 3;
		if (m[2] && (m[1] || m[0] || keep[0]))
			keep = keep + 1;
		if (keep[24]) begin
			keep = keep >> 1;
			e++;
		end
		if (e >= 255)
			return {s, 8'hFF, 23'd0};
		return {s, keep[23] ? 8'(e) : 8'd0, keep[22:0]};
	endfunction

	function automatic logic [31:0] fp_add(input logic [31:0] a, input logic [31:0] b);
		int ea, eb, d, tmp_e;
		logic [127:0] ma, mb, tmp_m, m;
		logic sa, sb, tmp_s, s;
		if (is_nan(a) || is_nan(b))
			return QNAN;
		if (is_inf(a)) begin
			if (is_inf(b) && a[31] != b[31])
				return QNAN;
			return a;
		end
		if (is_inf(b))
			return b;
		if (is_zero(a) && is_zero(b))
			return {a[31] & b[31], 31'd0};
		split(a, ea, ma);
		split(b, eb, mb);
		sa = a[31];
		sb = b[31];
		ma = ma << 3;
		mb = mb << 3;
		if (ea < eb) begin
			tmp_e = ea; ea = eb; eb = tmp_e;
			tmp_m = ma; ma = mb; mb = tmp_m;
			tmp_s = sa; sa = sb; sb = tmp_s;
		end
		d = ea - eb;
		if (d > 40)
			mb = (mb != 0) ? 128'd1 : 128'd0;
		else
			for (int k = 0; k < d; k++)
				mb = (mb >> 1) | (mb & 128'd1);
		if (sa == sb) begin
			m = ma + mb;
			s = sa;
		end else if (ma >= mb) begin
			m = ma - mb;
			s = sa;
		end else begin
			m = mb - ma;
			s = sb;
		end
		if (m == 0)
			return 32'd0;
		return round_pack(s, ea, m);
	endfunction

	function automatic logic [31:0] fp_sub(input logic [31:0] a, input logic [31:0] b);
		return fp_add(a, {~b[31], b[30:0]});
	endfunction

	function automatic logic [31:0] fp_mul(input logic [31:0] a, input logic [31:0] b);
		int ea, eb;
		logic [127:0] ma, mb;
		logic s;
		s = a[31] ^ b[31];
		if (is_nan(a) || is_nan(b))
			return QNAN;
		if ((is_inf(a) && is_zero(b)) || (is_zero(a) && is_inf(b)))
			return QNAN;
		if (is_inf(a) || is_inf(b))
			return {s, 8'hFF, 23'd0};
		if (is_zero(a) || is_zero(b))
			return {s, 31'd0};
		split(a, ea, ma);
		split(b, eb, mb);
		return round_pack(s, ea + eb - 147, ma * mb);
	endfunction

	// Division with the zero-divisor rule: NaN for a zero or NaN numerator, else signed infinity
	function automatic logic [31:0] fp_div(input logic [31:0] a, input logic [31:0] b);
		int ea, eb;
		logic [127:0] ma, mb, q;
		logic s;
		s = a[31] ^ b[31];
		if (is_zero(b)) begin
			if (is_zero(a) || is_nan(a))
				return QNAN;
			return {s, 8'hFF, 23'd0};
		end
		if (is_nan(a) || is_nan(b))
			return QNAN;
		if (is_inf(a)) begin
			if (is_inf(b))
				return QNAN;
			return {s, 8'hFF, 23'd0};
		end
		if (is_inf(b) || is_zero(a))
			return {s, 31'd0};
		split(a, ea, ma);
		split(b, eb, mb);
		q = (ma << 60) / mb;
		if ((ma << 60) % mb != 0)
			q = q | 128'd1;
		return round_pack(s, ea - eb + 93, q);
	endfunction

	function automatic logic fp_lt(input logic [31:0] a, input logic [31:0] b);
		if (is_nan(a) || is_nan(b))
			return 1'b0;
		if (is_zero(a) && is_zero(b))
			return 1'b0;
		if (a[31] != b[31])
			return a[31];
		if (!a[31])
			return a[30:0] < b[30:0];
		return a[30:0] > b[30:0];
	endfunction

	// Run the sweeps and queue one expected element per unknown
	task automatic solve_vector();
		logic [31:0] cur[MAX_N];
		logic [31:0] nxt[MAX_N];
		logic [31:0] sum, change;
		int n, sweeps;
		logic conv;
		solution_t r;
		n = int'(size_reg);
		if (n < 1)
			n = 1;
		if (n > MAX_N)
			n = MAX_N;
		sweeps = 0;
		conv = 1'b0;
		for (int i = 0; i < MAX_N; i++) begin
			cur[i] = 32'd0;
			nxt[i] = 32'd0;
		end
		while (sweeps < int'(limit_reg)) begin
			change = 32'd0;
			for (int i = 0; i < n; i++) begin
				sum = 32'd0;
				for (int j = 0; j < n; j++)
					if (j != i)
						sum = fp_add(sum, fp_mul(mat_mem[i*MAX_N+j], cur[j]));
				nxt[i] = fp_div(fp_sub(rhs_mem[i], sum), mat_mem[i*MAX_N+i]);
			end
			for (int i = 0; i < n; i++)
				change = fp_add(change, fp_sub(nxt[i], cur[i]) & 32'h7FFFFFFF);
			for (int i = 0; i < n; i++)
				cur[i] = nxt[i];
			sweeps++;
			if (fp_lt(change, acc_reg)) begin
				conv = 1'b1;
				break;
			end
		end
		for (int i = 0; i < n; i++) begin
			r.index       = 5'(i);
			r.solution    = cur[i];
			r.converged   = conv;
			r.sweeps_used = 16'(sweeps);
			r.last        = (i + 1 == n);
			solution_q.push_back(r);
		end
	endtask

	// Track configuration, apply requests and compare results
	always @(posedge clk or negedge arst_n) begin
		solution_t exp_r;
		logic nan_ok;
		if (!arst_n) begin
			size_reg    <= SIZE_RESET;
			acc_reg     <= ACCURACY_RESET;
			limit_reg   <= LIMIT_RESET;
			fails       <= 0;
			outstanding <= 0;
		end else begin
			if (cfg.valid && cfg.ready) begin
				case (cfg.index)
					REG_SIZE:     size_reg  <= cfg.data[5:0];
					REG_ACCURACY: acc_reg   <= cfg.data;
					REG_LIMIT:    limit_reg <= cfg.data[15:0];
					default: ;
				endcase
			end
			if (req.valid && req.ready) begin
				case (req.command)
					CMD_MATRIX: mat_mem[int'(req.row)*MAX_N + int'(req.col)] = req.value;
					CMD_RHS:    rhs_mem[req.row] = req.value;
					CMD_SOLVE:  solve_vector();
					default: ;
				endcase
			end
			if (rsp.valid && rsp.ready) begin
				if (solution_q.size() == 0) begin
					$display("%0t: result with none expected, index %0d", $time, rsp.index);
					fails <= fails + 1;
				end else begin
					exp_r = solution_q.pop_front();
					nan_ok = is_nan(exp_r.solution) && is_nan(rsp.solution);
					if (rsp.index !== exp_r.index ||
					    (rsp.solution !== exp_r.solution && !nan_ok) ||
					    rsp.converged !== exp_r.converged ||
					    rsp.sweeps_used !== exp_r.sweeps_used ||
					    rsp.last !== exp_r.last) begin
						$display("%0t: mismatch expected idx %0d x %h conv %b sw %0d last %b",
							$time, exp_r.index, exp_r.solution, exp_r.converged,
							exp_r.sweeps_used, exp_r.last);
						$display("%0t:          actual   idx %0d x %h conv %b sw %0d last %b",
							$time, rsp.index, rsp.solution, rsp.converged,
							rsp.sweeps_used, rsp.last);
						fails <= fails + 1;
					end
				end
			end
			outstanding <= solution_q.size();
		end
	end

endmodule

// ===== tb/sv/jacobi_linear_solver_tb.sv =====
`timescale 1ns / 100ps

module jacobi_linear_solver_tb;
	import jls_pkg::*;

	localparam int MAX_N = 32;

	logic clk;
	logic arst_n;
	int   fails;
	int   outstanding;
	int   rand_items;
	bit   steady;
	bit   rsp_hold;
	int   hold_cnt;

	jls_req_if req_ch();
	jls_rsp_if rsp_ch();
	jls_cfg_if cfg_ch();

	jacobi_linear_solver #(.MAX_N(MAX_N)) dut (
		.clk(clk), .arst_n(arst_n), .req_ch(req_ch), .rsp_ch(rsp_ch), .cfg(cfg_ch)
	);

	jacobi_linear_solver_chk #(.MAX_N(MAX_N)) chk (
		.clk(clk), .arst_n(arst_n), .req(req_ch), .rsp(rsp_ch), .cfg(cfg_ch),
		.fails(fails), .outstanding(outstanding)
	);

	initial clk = 1'b0;
	always #1 clk = ~clk;

	// Bound the run
	initial begin
		#40000000;
		$display("FAILURE");
		$finish;
	end

	// Drive result ready: random stalls, a long hold-off on request
	initial begin
		rsp_ch.ready <= 1'b0;
		hold_cnt = 0;
		forever begin
			@(posedge clk);
			if (rsp_hold) begin
				rsp_hold = 1'b0;
				hold_cnt = 3000;
			end
			if (hold_cnt > 0) begin
				hold_cnt--;
				rsp_ch.ready <= 1'b0;
			end else begin
				rsp_ch.ready <= steady || ($urandom_range(99) >= 34);
			end
		end
	end

	function automatic logic [31:0] off_val();
		return {1'($urandom_range(1)), 8'($urandom_range(118, 126)), 23'($urandom)};
	endfunction

	function automatic logic [31:0] diag_val();
		return {1'($urandom_range(1)), 8'($urandom_range(133, 135)), 23'($urandom)};
	endfunction

	function automatic logic [31:0] rhs_val();
		return {1'($urandom_range(1)), 8'($urandom_range(120, 134)), 23'($urandom)};
	endfunction

	task automatic send(input logic [1:0] cmd, input int row, input int col,
			input logic [31:0] val);
		if (!steady && $urandom_range(99) < 34) begin
			req_ch.valid <= 1'b0;
			repeat ($urandom_range(1, 4)) @(posedge clk);
		end
		req_ch.command <= cmd;
		req_ch.row     <= 5'(row);
		req_ch.col     <= 5'(col);
		req_ch.value   <= val;
		req_ch.valid   <= 1'b1;
		do @(posedge clk); while (!req_ch.ready);
		rand_items++;
	endtask

	task automatic write_reg(input logic [1:0] idx, input logic [31:0] data);
		cfg_ch.index <= idx;
		cfg_ch.data  <= data;
		cfg_ch.valid <= 1'b1;
		do @(posedge clk); while (!cfg_ch.ready);
		cfg_ch.valid <= 1'b0;
	endtask

	// Drop the request and wait for every expected element to drain
	task automatic drain();
		req_ch.valid <= 1'b0;
		@(posedge clk);
		while (outstanding != 0)
			@(posedge clk);
		repeat (30) @(posedge clk);
	endtask

	task automatic configure(input logic [5:0] n, input logic [31:0] acc, input logic [15:0] lim);
		drain();
		write_reg(REG_SIZE, {26'd0, n});
		write_reg(REG_ACCURACY, acc);
		write_reg(REG_LIMIT, {16'd0, lim});
	endtask

	// Load an n by n system, dominant unless garbage, with noise mixed in
	task automatic load_system(input int n, input bit garbage);
		for (int i = 0; i < n; i++) begin
			for (int j = 0; j < n; j++) begin
				if ($urandom_range(99) < 8)
					send(2'd3, $urandom_range(31), $urandom_range(31), $urandom);
				if ($urandom_range(99) < 8)
					send(CMD_MATRIX, i, j, $urandom);
				if (garbage)
					send(CMD_MATRIX, i, j, $urandom);
				else
					send(CMD_MATRIX, i, j, (i == j) ? diag_val() : off_val());
			end
			send(CMD_RHS, i, $urandom_range(31), garbage ? $urandom : rhs_val());
		end
	endtask

	initial begin
		int n;
		bit garbage;
		logic [31:0] acc;
		logic [15:0] lim;
		logic [5:0] size_w;
		req_ch.valid   <= 1'b0;
		req_ch.command <= CMD_MATRIX;
		req_ch.row     <= 5'd0;
		req_ch.col     <= 5'd0;
		req_ch.value   <= 32'd0;
		cfg_ch.valid   <= 1'b0;
		cfg_ch.index   <= REG_SIZE;
		cfg_ch.data    <= 32'd0;
		steady   = 1'b0;
		rsp_hold = 1'b0;
		arst_n   = 1'b0;
		repeat (11) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Directed: a small well-posed system
		configure(6'd2, ACCURACY_RESET, 16'd1000);
		send(CMD_MATRIX, 0, 0, 32'h40800000);
		send(CMD_MATRIX, 0, 1, 32'h3F800000);
		send(CMD_MATRIX, 1, 0, 32'hBF800000);
		send(CMD_MATRIX, 1, 1, 32'h40400000);
		send(CMD_RHS, 0, 31, 32'h3F800000);
		send(CMD_RHS, 1, 0, 32'h40000000);
		send(CMD_SOLVE, 31, 31, 32'hFFFFFFFF);
		// Zero sweep limit, then a NaN threshold
		configure(6'd2, 32'hFFFFFFFF, 16'd0);
		send(CMD_SOLVE, 0, 0, 32'd0);
		configure(6'd2, 32'hFFFFFFFF, 16'd3);
		send(CMD_SOLVE, 0, 0, 32'd0);
		// Zero diagonal: infinity, then zero over zero
		configure(6'd2, 32'd0, 16'd1);
		send(CMD_MATRIX, 1, 1, 32'h00000000);
		send(CMD_SOLVE, 0, 0, 32'd0);
		send(CMD_MATRIX, 1, 0, 32'h80000000);
		send(CMD_RHS, 1, 0, 32'h00000000);
		send(CMD_SOLVE, 0, 0, 32'd0);
		// Unused command and extreme indexes
		send(2'd3, 31, 31, 32'hFFFFFFFF);
		send(CMD_MATRIX, 31, 31, 32'hFFFFFFFF);
		send(CMD_MATRIX, 31, 0, 32'h00000001);
		send(CMD_RHS, 31, 31, 32'h7F800000);
		// Size zero acts as one
		configure(6'd0, 32'h7F7FFFFF, 16'd65535);
		send(CMD_SOLVE, 0, 0, 32'd0);

		// Random systems; the first one runs without idling and under a long hold-off
		rand_items = 0;
		while (rand_items < 160) begin
			garbage = ($urandom_range(99) < 20);
			n = ($urandom_range(99) < 70) ? $urandom_range(1, 4) : $urandom_range(5, 8);
			case ($urandom_range(5))
				0: acc = ACCURACY_RESET;
				1: acc = 32'd0;
				2: acc = 32'h7F7FFFFF;
				3: acc = {1'b0, 8'($urandom_range(100, 125)), 23'($urandom)};
				4: acc = 32'hFFFFFFFF;
				default: acc = $urandom;
			endcase
			if (garbage || acc == 32'd0 || acc[30:23] == 8'hFF || acc[30:23] < 8'd100)
				lim = 16'($urandom_range(1, 4));
			else if (acc == 32'h7F7FFFFF)
				lim = ($urandom_range(1)) ? 16'd65535 : 16'($urandom_range(1, 20));
			else if ($urandom_range(3) == 0)
				lim = 16'd1000;
			else
				lim = 16'($urandom_range(1, 20));
			size_w = (n == 1 && $urandom_range(1)) ? 6'd0 : 6'(n);
			configure(size_w, acc, lim);
			steady = (rand_items == 0) || ($urandom_range(99) < 15);
			if (rand_items == 0 || $urandom_range(99) < 15)
				rsp_hold = 1'b1;
			load_system(n, garbage);
			send(CMD_SOLVE, $urandom_range(31), $urandom_range(31), $urandom);
			// Offer more loads behind the solve so the input backs up
			if ($urandom_range(1))
				load_system(n, garbage);
			send(CMD_SOLVE, $urandom_range(31), $urandom_range(31), $urandom);
			steady = 1'b0;
		end

		drain();
		repeat (100) @(posedge clk);
		if (fails == 0 && outstanding == 0) begin
			$display("SUCCESS");
		end else begin
			$display("FAILURE");
		end
		$finish;
	end

endmodule
